// File: rtl/pll_divider_search_core_macros.svh
// Assertion macros for the PLL divider search core.
// Every check is sampled on i_clk and is held off while i_rst_n is low.
`ifndef PLL_DIVIDER_SEARCH_CORE_MACROS_SVH
`define PLL_DIVIDER_SEARCH_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/pds_pkg.sv
package pds_pkg;

    localparam int unsigned IN_W  = 32;
    localparam int unsigned M_W   = 10;
    localparam int unsigned N_W   = 4;
    localparam int unsigned C_W   = 10;
    localparam int unsigned ACH_W = 31;

    localparam logic [31:0] PFD_MIN_HZ  = 32'd5000000;
    localparam logic [31:0] VCO_LOW_HZ  = 32'd600000000;
    localparam logic [31:0] VCO_HIGH_HZ = 32'd1300000000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NCHK,
        S_MCHK,
        S_DIV0,
        S_CAND,
        S_MUL,
        S_CMP,
        S_FIN,
        S_DIV1,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic next_n;
        logic start_m;
        logic next_m;
        logic div_c0;
        logic div_fin;
        logic div_step;
        logic cand_init;
        logic cand_load;
        logic cand_next;
        logic mul_step;
        logic cand_update;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic want_zero;
        logic n_done;
        logic pfd_low;
        logic m_done;
        logic vco_ok;
        logic div_last;
        logic cand_ok;
        logic cand_last;
        logic mul_last;
        logic better;
        logic have;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/pds_if.sv
interface pds_in_if;
    logic                       valid;
    logic                       ready;
    logic [pds_pkg::IN_W-1:0]   reference_hz;
    logic [pds_pkg::IN_W-1:0]   wanted_hz;

    modport source (output valid, output reference_hz, output wanted_hz, input ready);
    modport sink   (input valid, input reference_hz, input wanted_hz, output ready);
endinterface

interface pds_out_if;
    logic                       valid;
    logic                       ready;
    logic [pds_pkg::M_W-1:0]    divider_m;
    logic [pds_pkg::N_W-1:0]    divider_n;
    logic [pds_pkg::C_W-1:0]    divider_c;
    logic [pds_pkg::ACH_W-1:0]  achieved_hz;
    logic                       found;

    modport source (output valid, output divider_m, output divider_n, output divider_c,
                    output achieved_hz, output found, input ready);
    modport sink   (input valid, input divider_m, input divider_n, input divider_c,
                    input achieved_hz, input found, output ready);
endinterface

// File: rtl/pds_ctrl.sv
module pds_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pds_pkg::t_stat  i_stat,
    output pds_pkg::t_cmd   o_cmd
);

    pds_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pds_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            pds_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = pds_pkg::S_NCHK;
                end
            end
            pds_pkg::S_NCHK: begin
                if (i_stat.want_zero || i_stat.n_done) begin
                    n_state = pds_pkg::S_FIN;
                end else if (i_stat.pfd_low) begin
                    o_cmd.next_n = 1'b1;
                end else begin
                    o_cmd.start_m = 1'b1;
                    n_state       = pds_pkg::S_MCHK;
                end
            end
            pds_pkg::S_MCHK: begin
                if (i_stat.m_done) begin
                    o_cmd.next_n = 1'b1;
                    n_state      = pds_pkg::S_NCHK;
                end else if (!i_stat.vco_ok) begin
                    o_cmd.next_m = 1'b1;
                end else begin
                    o_cmd.div_c0 = 1'b1;
                    n_state      = pds_pkg::S_DIV0;
                end
            end
            pds_pkg::S_DIV0: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    o_cmd.cand_init = 1'b1;
                    n_state         = pds_pkg::S_CAND;
                end
            end
            pds_pkg::S_CAND: begin
                if (i_stat.cand_ok) begin
                    o_cmd.cand_load = 1'b1;
                    n_state         = pds_pkg::S_MUL;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    if (i_stat.cand_last) begin
                        o_cmd.next_m = 1'b1;
                        n_state      = pds_pkg::S_MCHK;
                    end
                end
            end
            pds_pkg::S_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_stat.mul_last) begin
                    n_state = pds_pkg::S_CMP;
                end
            end
            pds_pkg::S_CMP: begin
                o_cmd.cand_update = i_stat.better;
                o_cmd.cand_next   = 1'b1;
                if (i_stat.cand_last) begin
                    o_cmd.next_m = 1'b1;
                    n_state      = pds_pkg::S_MCHK;
                end else begin
                    n_state = pds_pkg::S_CAND;
                end
            end
            pds_pkg::S_FIN: begin
                if (i_stat.have) begin
                    o_cmd.div_fin = 1'b1;
                    n_state       = pds_pkg::S_DIV1;
                end else begin
                    n_state = pds_pkg::S_OUT;
                end
            end
            pds_pkg::S_DIV1: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = pds_pkg::S_OUT;
                end
            end
            pds_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = pds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pds_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/pds_datapath.sv
module pds_datapath #(
    parameter int unsigned PREDIV_MAX  = 10,
    parameter int unsigned MULT_MAX    = 512,
    parameter int unsigned POSTDIV_MAX = 512
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pds_pkg::t_cmd               i_cmd,
    output pds_pkg::t_stat              o_stat,
    input  logic [pds_pkg::IN_W-1:0]    i_reference_hz,
    input  logic [pds_pkg::IN_W-1:0]    i_wanted_hz,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [pds_pkg::M_W-1:0]     o_divider_m,
    output logic [pds_pkg::N_W-1:0]     o_divider_n,
    output logic [pds_pkg::C_W-1:0]     o_divider_c,
    output logic [pds_pkg::ACH_W-1:0]   o_achieved_hz,
    output logic                        o_found
);

    localparam int unsigned NCW = $clog2(PREDIV_MAX + 2);
    localparam int unsigned NW  = $clog2(PREDIV_MAX + 1);
    localparam int unsigned MCW = $clog2(MULT_MAX + 2);
    localparam int unsigned MW  = $clog2(MULT_MAX + 1);
    localparam int unsigned CW  = $clog2(POSTDIV_MAX + 1);
    localparam int unsigned VW  = pds_pkg::IN_W + MW;
    localparam int unsigned TW  = pds_pkg::IN_W + NW;
    localparam int unsigned DW  = ((VW > TW) ? VW : TW) + 2;
    localparam int unsigned DNW = NW + CW;
    localparam int unsigned NMW = TW + 1;
    localparam int unsigned SW  = TW + 3;
    localparam int unsigned PW  = NMW + DNW;
    localparam int unsigned DCW = $clog2(DW);
    localparam int unsigned MUW = $clog2(DNW);

    // Offset of the post-divider candidate from the rounded quotient.
    localparam logic [1:0] K_BELOW = 2'd0;
    localparam logic [1:0] K_AT    = 2'd1;
    localparam logic [1:0] K_ABOVE = 2'd2;

    logic [pds_pkg::IN_W-1:0] r_ref, r_want;
    logic [NCW-1:0]           r_n;
    logic [MCW-1:0]           r_m;
    logic [VW-1:0]            r_vnum;
    logic [TW-1:0]            r_tn;
    logic [DW-1:0]            r_pfd, r_lo, r_hi;

    logic [DW:0]              r_rem;
    logic [DW-1:0]            r_quo, r_dvs;
    logic [DCW-1:0]           r_dcnt;

    logic [1:0]               r_k;
    logic [CW-1:0]            r_c;
    logic [NMW-1:0]           r_cnum;
    logic [DNW-1:0]           r_cden;

    logic [MUW-1:0]           r_mcnt;
    logic [PW-1:0]            r_a1, r_a2, r_sh1, r_sh2;
    logic [DNW-1:0]           r_bd, r_dd;

    logic                     r_have;
    logic [NMW-1:0]           r_bnum;
    logic [DNW-1:0]           r_bden;
    logic [MW-1:0]            r_bm;
    logic [NW-1:0]            r_bn;
    logic [CW-1:0]            r_bc;
    logic [VW-1:0]            r_bvnum;

    logic                     r_ov;

    logic [DW:0]              w_rem_sh;
    logic [DW:0]              w_ck;
    logic signed [SW-1:0]     w_diff, w_d0, w_tn_s, w_dk, w_abs;
    logic [DNW-1:0]           w_den;

    always_comb begin
        w_rem_sh = {r_rem[DW-1:0], r_quo[DW-1]};
        w_ck     = (DW+1)'(r_quo) + (DW+1)'(r_k) - (DW+1)'(1);
        // The division remainder gives vco minus wanted*c0, doubled and offset.
        w_tn_s   = $signed({3'b000, r_tn});
        w_diff   = $signed({2'b00, r_rem[TW:0]}) - w_tn_s;
        w_d0     = w_diff >>> 1;
        case (r_k)
            K_BELOW: w_dk = w_d0 + w_tn_s;
            K_AT:    w_dk = w_d0;
            default: w_dk = w_d0 - w_tn_s;
        endcase
        w_abs    = w_dk[SW-1] ? -w_dk : w_dk;
        w_den    = DNW'(r_n[NW-1:0]) * DNW'(w_ck[CW-1:0]);
    end

    always_comb begin
        o_stat.want_zero = (r_want == '0);
        o_stat.n_done    = (r_n > NCW'(PREDIV_MAX));
        o_stat.pfd_low   = (DW'(r_ref) < r_pfd);
        o_stat.m_done    = (r_m > MCW'(MULT_MAX));
        o_stat.vco_ok    = (DW'(r_vnum) >= r_lo) && (DW'(r_vnum) <= r_hi);
        o_stat.div_last  = (r_dcnt == DCW'(DW - 1));
        o_stat.cand_ok   = (w_ck != '0) && (w_ck <= (DW+1)'(POSTDIV_MAX));
        o_stat.cand_last = (r_k == K_ABOVE);
        o_stat.mul_last  = (r_mcnt == MUW'(DNW - 1));
        o_stat.better    = !r_have || (r_a1 < r_a2);
        o_stat.have      = r_have;
        o_stat.out_free  = !r_ov || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ref   <= i_reference_hz;
            r_want  <= i_wanted_hz;
            r_n     <= NCW'(1);
            r_tn    <= TW'(i_wanted_hz);
            r_pfd   <= DW'(pds_pkg::PFD_MIN_HZ);
            r_lo    <= DW'(pds_pkg::VCO_LOW_HZ);
            r_hi    <= DW'(pds_pkg::VCO_HIGH_HZ);
            r_have  <= 1'b0;
            r_bnum  <= '0;
            r_bden  <= DNW'(1);
            r_bm    <= '0;
            r_bn    <= NW'(1);
            r_bc    <= CW'(1);
        end
        if (i_cmd.next_n) begin
            r_n   <= r_n + NCW'(1);
            r_tn  <= r_tn + TW'(r_want);
            r_pfd <= r_pfd + DW'(pds_pkg::PFD_MIN_HZ);
            r_lo  <= r_lo + DW'(pds_pkg::VCO_LOW_HZ);
            r_hi  <= r_hi + DW'(pds_pkg::VCO_HIGH_HZ);
        end
        if (i_cmd.start_m) begin
            r_m    <= MCW'(1);
            r_vnum <= VW'(r_ref);
        end
        if (i_cmd.next_m) begin
            r_m    <= r_m + MCW'(1);
            r_vnum <= r_vnum + VW'(r_ref);
        end

        // Restoring divider, one quotient bit a cycle; dividend bits shift out of r_quo.
        if (i_cmd.div_c0) begin
            r_quo  <= DW'({r_vnum, 1'b0}) + DW'(r_tn);
            r_dvs  <= DW'({r_tn, 1'b0});
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_fin) begin
            r_quo  <= DW'({r_bvnum, 1'b0}) + DW'(r_bden);
            r_dvs  <= DW'({r_bden, 1'b0});
            r_rem  <= '0;
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            if (w_rem_sh >= (DW+1)'(r_dvs)) begin
                r_rem <= w_rem_sh - (DW+1)'(r_dvs);
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt + DCW'(1);
        end

        if (i_cmd.cand_init) begin
            r_k <= K_BELOW;
        end
        if (i_cmd.cand_next) begin
            r_k <= r_k + 2'd1;
        end

        // Both cross products are formed by shift and add over the denominator bits.
        if (i_cmd.cand_load) begin
            r_c    <= w_ck[CW-1:0];
            r_cnum <= w_abs[NMW-1:0];
            r_cden <= w_den;
            r_sh1  <= PW'(w_abs[NMW-1:0]);
            r_sh2  <= PW'(r_bnum);
            r_bd   <= r_bden;
            r_dd   <= w_den;
            r_a1   <= '0;
            r_a2   <= '0;
            r_mcnt <= '0;
        end
        if (i_cmd.mul_step) begin
            if (r_bd[0]) begin
                r_a1 <= r_a1 + r_sh1;
            end
            if (r_dd[0]) begin
                r_a2 <= r_a2 + r_sh2;
            end
            r_sh1  <= r_sh1 << 1;
            r_sh2  <= r_sh2 << 1;
            r_bd   <= r_bd >> 1;
            r_dd   <= r_dd >> 1;
            r_mcnt <= r_mcnt + MUW'(1);
        end

        if (i_cmd.cand_update) begin
            r_have  <= 1'b1;
            r_bnum  <= r_cnum;
            r_bden  <= r_cden;
            r_bm    <= r_m[MW-1:0];
            r_bn    <= r_n[NW-1:0];
            r_bc    <= r_c;
            r_bvnum <= r_vnum;
        end

        if (i_cmd.out_load) begin
            o_divider_m   <= pds_pkg::M_W'(r_bm);
            o_divider_n   <= pds_pkg::N_W'(r_bn);
            o_divider_c   <= pds_pkg::C_W'(r_bc);
            o_achieved_hz <= r_have ? r_quo[pds_pkg::ACH_W-1:0] : '0;
            o_found       <= r_have;
        end
    end

    assign o_out_valid = r_ov;

endmodule

// File: rtl/pll_divider_search_core.sv
// Search order: a zero wanted frequency skips to the result; otherwise each pre-divider and
// multiplier is tried in turn, a serial division is run per multiplier with the VCO in range, each
// in-range post-divider candidate gets an exact error compare, and a final division of the best
// candidate gives the achieved frequency.
// One word is searched at a time; the result register lets the next word enter.
// Synchronous active-low reset returns the controller to idle and empties the result.
module pll_divider_search_core #(
    parameter int unsigned PREDIV_MAX  = 10,
    parameter int unsigned MULT_MAX    = 512,
    parameter int unsigned POSTDIV_MAX = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pds_in_if.sink      i_in,
    pds_out_if.source   o_out
);

    pds_pkg::t_cmd  w_cmd;
    pds_pkg::t_stat w_stat;

    pds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pds_datapath #(
        .PREDIV_MAX  (PREDIV_MAX),
        .MULT_MAX    (MULT_MAX),
        .POSTDIV_MAX (POSTDIV_MAX)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_reference_hz (i_in.reference_hz),
        .i_wanted_hz    (i_in.wanted_hz),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_divider_m    (o_out.divider_m),
        .o_divider_n    (o_out.divider_n),
        .o_divider_c    (o_out.divider_c),
        .o_achieved_hz  (o_out.achieved_hz),
        .o_found        (o_out.found)
    );

endmodule

// File: rtl/pds_checker.sv
`include "pll_divider_search_core_macros.svh"

module pds_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [pds_pkg::M_W-1:0]     i_divider_m,
    input  logic [pds_pkg::N_W-1:0]     i_divider_n,
    input  logic [pds_pkg::C_W-1:0]     i_divider_c,
    input  logic [pds_pkg::ACH_W-1:0]   i_achieved_hz,
    input  logic                        i_found
);

    // A result word waiting to be taken stays offered.
    `PDS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result word dropped")

    // Only one search runs at a time, so input closes once a word is taken.
    `PDS_ASSERT_NEXT(a_in_close, i_in_valid && i_in_ready, !i_in_ready, "input open during search")

    `PDS_ASSERT_SAME(a_not_found, i_out_valid && !i_found,
        (i_divider_m == '0) && (i_divider_n == 4'd1) && (i_divider_c == 10'd1) &&
        (i_achieved_hz == '0), "bad not-found word")

    `PDS_ASSERT_SAME(a_found_set, i_out_valid && i_found,
        (i_divider_m != '0) && (i_divider_n != '0) && (i_divider_c != '0),
        "zero divider in found word")

endmodule

bind pll_divider_search_core pds_checker u_pds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_divider_m   (o_out.divider_m),
    .i_divider_n   (o_out.divider_n),
    .i_divider_c   (o_out.divider_c),
    .i_achieved_hz (o_out.achieved_hz),
    .i_found       (o_out.found)
);
